FILE: hw/rtl/rgb_led_pattern_generator_macros.svh
// assertion helpers used by the checker file
`ifndef RGB_LED_PATTERN_GENERATOR_MACROS_SVH
`define RGB_LED_PATTERN_GENERATOR_MACROS_SVH

// plain concurrent check on the rising clock
`define RLPG_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("rlpg check failed");

// same, switched off while reset is high
`define RLPG_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rlpg check failed");

`endif

FILE: hw/rtl/rlpg_pkg.sv
package rlpg_pkg;

   localparam int unsigned CMD_W      = 3;
   localparam int unsigned MODE_W     = 3;
   localparam int unsigned CHAN_W     = 8;
   localparam int unsigned RND_W      = 32;
   localparam int unsigned HUE_W      = 9;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 8;
   localparam int unsigned NUM_MODES  = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_BUTTON    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET_MODE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_COLOR = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LED_OFF   = 3'd4;

   // pattern modes
   localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FLASH   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BREATHE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_STROBE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_PERIOD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BREATHE_PERIOD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STROBE_PERIOD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAINBOW_PERIOD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RAINBOW_BRIGHT = 3'd4;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rlpg_rgb_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MOD,
      ST_HSV_Q,
      ST_HSV_T,
      ST_HSV_PACK,
      ST_FINISH
   } rlpg_state_type;

endpackage

FILE: hw/rtl/rlpg_req_if.sv
interface rlpg_req_if;
   logic                           valid;
   logic                           ready;
   logic [rlpg_pkg::CMD_W-1:0]     command;
   logic [rlpg_pkg::CHAN_W-1:0]    mode_value;
   logic [rlpg_pkg::CHAN_W-1:0]    red_in;
   logic [rlpg_pkg::CHAN_W-1:0]    green_in;
   logic [rlpg_pkg::CHAN_W-1:0]    blue_in;
   logic [rlpg_pkg::RND_W-1:0]     random_word;

   modport source (output valid, command, mode_value, red_in, green_in, blue_in,
                   random_word, input ready);
   modport sink   (input valid, command, mode_value, red_in, green_in, blue_in,
                   random_word, output ready);
endinterface

FILE: hw/rtl/rlpg_rsp_if.sv
interface rlpg_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rlpg_pkg::CHAN_W-1:0]    red;
   logic [rlpg_pkg::CHAN_W-1:0]    green;
   logic [rlpg_pkg::CHAN_W-1:0]    blue;
   logic [rlpg_pkg::MODE_W-1:0]    mode;
   logic                           color_changed;

   modport source (output valid, red, green, blue, mode, color_changed, input ready);
   modport sink   (input valid, red, green, blue, mode, color_changed, output ready);
endinterface

FILE: hw/rtl/rgb_led_pattern_generator.sv
// channel   dir   handshake             payload
// req_bus   in    valid/ready           command, mode_value, red_in, green_in, blue_in,
//                                       random_word
// rsp_bus   out   valid/ready           red, green, blue, mode, color_changed
// csr_*     in    csr_we (no stall)     csr_index, csr_wdata
//
// an item goes from exec to finish when no hue math is needed; an hsv color adds
// the hsv_q, hsv_t and hsv_pack states and a random hue pick adds the mod states;
// the random hue walks the mod-360 remainder 4 bits a cycle and the hsv path runs
// its two 8x8 products through one shared multiplier
// reset is synchronous: pattern state and registers take their reset values at once
// a waiting response beat does not block the next request beat, only the next result

module rgb_led_pattern_generator (
   input  logic                               clock,
   input  logic                               reset,
   rlpg_req_if.sink                           req_bus,
   rlpg_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [rlpg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rlpg_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned MOD_DIGIT_W = 4;
   localparam int unsigned MOD_STEPS   = rlpg_pkg::RND_W / MOD_DIGIT_W;
   localparam int unsigned MOD_CNT_W   = $clog2(MOD_STEPS);
   localparam int unsigned HUE_SPAN    = 360;
   localparam int unsigned CW          = rlpg_pkg::CHAN_W;
   localparam logic [CW-1:0] CHAN_MAX  = 8'hFF;
   localparam logic [CW-1:0] BREATHE_STEP = 8'd3;

   // sequencer
   rlpg_pkg::rlpg_state_type state_ff, state_in;

   // latched request beat
   logic [rlpg_pkg::CMD_W-1:0]  cmd_ff, cmd_in;
   logic [CW-1:0]               mval_ff, mval_in;
   rlpg_pkg::rlpg_rgb_type      rgb_req_ff, rgb_req_in;
   logic [rlpg_pkg::RND_W-1:0]  rnd_ff, rnd_in;     // also the shift line of the mod loop

   // configuration
   logic [CW-1:0] flash_period_ff, flash_period_in;
   logic [CW-1:0] breathe_period_ff, breathe_period_in;
   logic [CW-1:0] strobe_period_ff, strobe_period_in;
   logic [CW-1:0] rainbow_period_ff, rainbow_period_in;
   logic [CW-1:0] rainbow_bright_ff, rainbow_bright_in;

   // pattern state
   logic [rlpg_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [rlpg_pkg::HUE_W-1:0]  hue_ff, hue_in;
   logic [CW-1:0]               bright_ff, bright_in;
   logic                        fading_ff, fading_in;
   logic                        strobe_off_ff, strobe_off_in;
   rlpg_pkg::rlpg_rgb_type      led_ff, led_in;
   logic                        changed_ff, changed_in;

   // work flags and shared unit registers
   logic                        need_mod_ff, need_mod_in;
   logic                        need_hsv_ff, need_hsv_in;
   logic [CW-1:0]               v_ff, v_in;
   logic [rlpg_pkg::HUE_W-1:0]  rem_ff, rem_in;
   logic [MOD_CNT_W-1:0]        mod_cnt_ff, mod_cnt_in;
   logic [2*CW-1:0]             mul_ff, mul_in;
   logic [CW-1:0]               q_ff, q_in;

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   rlpg_pkg::rlpg_rgb_type      rsp_color_ff, rsp_color_in;
   logic [rlpg_pkg::MODE_W-1:0] rsp_mode_ff, rsp_mode_in;
   logic                        rsp_changed_ff, rsp_changed_in;

   // control
   logic accept;
   logic rsp_load;
   logic mod_last;
   logic mul_sel_t;

   // combinational helpers
   logic [rlpg_pkg::HUE_W-1:0]  rem_next;
   logic [2:0]                  sector;
   logic [5:0]                  rem60;
   logic [CW-1:0]               frac;
   logic [CW-1:0]               inv_a;
   logic [CW-1:0]               inv_b;
   logic [2*CW-1:0]             product;
   rlpg_pkg::rlpg_rgb_type      hsv_color;

   function automatic logic [CW-1:0] period_of(
      input logic [rlpg_pkg::MODE_W-1:0] m,
      input logic [CW-1:0]               fp,
      input logic [CW-1:0]               bp,
      input logic [CW-1:0]               sp,
      input logic [CW-1:0]               rp
   );
      logic [CW-1:0] p;
      unique case (m)
         rlpg_pkg::MODE_FLASH:   p = fp;
         rlpg_pkg::MODE_BREATHE: p = bp;
         rlpg_pkg::MODE_STROBE:  p = sp;
         default:                p = rp;
      endcase
      return p;
   endfunction

   // 255*x >> 8 is x - 1 for nonzero x
   function automatic logic [CW-1:0] scale_255(input logic [CW-1:0] x);
      logic [CW-1:0] r;
      r = (x == '0) ? '0 : x - 8'd1;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // control outputs
   // ------------------------------------------------------------------
   always_comb begin
      req_bus.ready = (state_ff == rlpg_pkg::ST_IDLE);
      accept        = req_bus.valid && req_bus.ready;
      rsp_load      = (state_ff == rlpg_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_bus.ready);
      mod_last      = (state_ff == rlpg_pkg::ST_MOD) && (mod_cnt_ff == MOD_CNT_W'(MOD_STEPS - 1));
      mul_sel_t     = (state_ff == rlpg_pkg::ST_HSV_T);
   end

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rlpg_pkg::ST_IDLE: begin
            if (accept) state_in = rlpg_pkg::ST_EXEC;
         end
         rlpg_pkg::ST_EXEC: begin
            if (need_mod_in)      state_in = rlpg_pkg::ST_MOD;
            else if (need_hsv_in) state_in = rlpg_pkg::ST_HSV_Q;
            else                  state_in = rlpg_pkg::ST_FINISH;
         end
         rlpg_pkg::ST_MOD: begin
            if (mod_last) state_in = need_hsv_ff ? rlpg_pkg::ST_HSV_Q : rlpg_pkg::ST_FINISH;
         end
         rlpg_pkg::ST_HSV_Q:    state_in = rlpg_pkg::ST_HSV_T;
         rlpg_pkg::ST_HSV_T:    state_in = rlpg_pkg::ST_HSV_PACK;
         rlpg_pkg::ST_HSV_PACK: state_in = rlpg_pkg::ST_FINISH;
         rlpg_pkg::ST_FINISH: begin
            if (rsp_load) state_in = rlpg_pkg::ST_IDLE;
         end
         default: state_in = rlpg_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // remainder mod 360, one 4-bit digit per cycle
   // ------------------------------------------------------------------
   always_comb begin
      logic [rlpg_pkg::HUE_W:0] acc;
      acc = {1'b0, rem_ff};
      for (int i = 0; i < MOD_DIGIT_W; i++) begin
         acc = {acc[rlpg_pkg::HUE_W-1:0], rnd_ff[rlpg_pkg::RND_W-1-i]};
         if (acc >= (rlpg_pkg::HUE_W+1)'(HUE_SPAN)) acc = acc - (rlpg_pkg::HUE_W+1)'(HUE_SPAN);
      end
      rem_next = acc[rlpg_pkg::HUE_W-1:0];
   end

   // ------------------------------------------------------------------
   // hsv sector, fraction and the shared multiplier
   // ------------------------------------------------------------------
   always_comb begin
      logic [9:0]    frac17;
      logic [CW-1:0] mul_b;
      logic [CW-1:0] t_val;
      priority if (hue_ff >= 9'd300) begin
         sector = 3'd5; rem60 = 6'(hue_ff - 9'd300);
      end else if (hue_ff >= 9'd240) begin
         sector = 3'd4; rem60 = 6'(hue_ff - 9'd240);
      end else if (hue_ff >= 9'd180) begin
         sector = 3'd3; rem60 = 6'(hue_ff - 9'd180);
      end else if (hue_ff >= 9'd120) begin
         sector = 3'd2; rem60 = 6'(hue_ff - 9'd120);
      end else if (hue_ff >= 9'd60) begin
         sector = 3'd1; rem60 = 6'(hue_ff - 9'd60);
      end else begin
         sector = 3'd0; rem60 = 6'(hue_ff);
      end
      // remainder * 255 / 60 is remainder * 17 / 4
      frac17  = ({4'b0, rem60} << 4) + {4'b0, rem60};
      frac    = frac17[9:2];
      inv_a   = CHAN_MAX - scale_255(frac);
      inv_b   = CHAN_MAX - scale_255(CHAN_MAX - frac);
      mul_b   = mul_sel_t ? inv_b : inv_a;
      product = {8'b0, v_ff} * {8'b0, mul_b};

      t_val = mul_ff[2*CW-1:CW];
      unique case (sector)
         3'd0:    hsv_color = '{red: v_ff,  green: t_val, blue: '0};
         3'd1:    hsv_color = '{red: q_ff,  green: v_ff,  blue: '0};
         3'd2:    hsv_color = '{red: '0,    green: v_ff,  blue: t_val};
         3'd3:    hsv_color = '{red: '0,    green: q_ff,  blue: v_ff};
         3'd4:    hsv_color = '{red: t_val, green: '0,    blue: v_ff};
         default: hsv_color = '{red: v_ff,  green: '0,    blue: q_ff};
      endcase
   end

   // ------------------------------------------------------------------
   // datapath next values
   // ------------------------------------------------------------------
   always_comb begin
      logic                        enter_go;
      logic [rlpg_pkg::MODE_W-1:0] enter_m;
      logic [rlpg_pkg::MODE_W-1:0] req_m;
      logic [CW:0]                 bright_up;

      cmd_in        = cmd_ff;
      mval_in       = mval_ff;
      rgb_req_in    = rgb_req_ff;
      rnd_in        = rnd_ff;
      mode_in       = mode_ff;
      cnt_in        = cnt_ff;
      hue_in        = hue_ff;
      bright_in     = bright_ff;
      fading_in     = fading_ff;
      strobe_off_in = strobe_off_ff;
      led_in        = led_ff;
      changed_in    = changed_ff;
      need_mod_in   = need_mod_ff;
      need_hsv_in   = need_hsv_ff;
      v_in          = v_ff;
      rem_in        = rem_ff;
      mod_cnt_in    = mod_cnt_ff;
      mul_in        = mul_ff;
      q_in          = q_ff;
      enter_go      = 1'b0;
      enter_m       = rlpg_pkg::MODE_OFF;
      req_m         = rlpg_pkg::MODE_OFF;
      bright_up     = {1'b0, bright_ff} + {1'b0, BREATHE_STEP};

      unique case (state_ff)
         rlpg_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in     = req_bus.command;
               mval_in    = req_bus.mode_value;
               rgb_req_in = '{red: req_bus.red_in, green: req_bus.green_in,
                              blue: req_bus.blue_in};
               rnd_in     = req_bus.random_word;
            end
         end

         rlpg_pkg::ST_EXEC: begin
            changed_in  = 1'b0;
            need_mod_in = 1'b0;
            need_hsv_in = 1'b0;
            rem_in      = '0;
            mod_cnt_in  = '0;
            unique case (cmd_ff)
               rlpg_pkg::CMD_TICK: begin
                  if (mode_ff != rlpg_pkg::MODE_OFF) begin
                     if (cnt_ff <= 8'd1) begin
                        changed_in = 1'b1;
                        cnt_in = period_of(mode_ff, flash_period_ff, breathe_period_ff,
                                           strobe_period_ff, rainbow_period_ff);
                        unique case (mode_ff)
                           rlpg_pkg::MODE_FLASH: begin
                              led_in = rlpg_pkg::rlpg_rgb_type'(rnd_ff[23:0]);
                           end
                           rlpg_pkg::MODE_BREATHE: begin
                              // rise to full, hold full once, fall to dark, new hue
                              if (!fading_ff) begin
                                 if (bright_ff == CHAN_MAX) fading_in = 1'b1;
                                 else bright_in = bright_up[CW] ? CHAN_MAX : bright_up[CW-1:0];
                              end else if (bright_ff == '0) begin
                                 fading_in   = 1'b0;
                                 need_mod_in = 1'b1;
                              end else begin
                                 bright_in = (bright_ff >= BREATHE_STEP) ?
                                             bright_ff - BREATHE_STEP : '0;
                              end
                              need_hsv_in = 1'b1;
                              v_in        = bright_in;
                           end
                           rlpg_pkg::MODE_STROBE: begin
                              if (strobe_off_ff) begin
                                 strobe_off_in = 1'b0;
                                 led_in = rlpg_pkg::rlpg_rgb_type'(rnd_ff[23:0]);
                              end else begin
                                 strobe_off_in = 1'b1;
                                 led_in        = '0;
                              end
                           end
                           default: begin
                              hue_in = (hue_ff == rlpg_pkg::HUE_W'(HUE_SPAN - 1)) ?
                                       '0 : hue_ff + 9'd1;
                              need_hsv_in = 1'b1;
                              v_in        = rainbow_bright_ff;
                           end
                        endcase
                     end else begin
                        cnt_in = cnt_ff - 8'd1;
                     end
                  end
               end
               rlpg_pkg::CMD_BUTTON: begin
                  enter_go = 1'b1;
                  enter_m  = (mode_ff == rlpg_pkg::MODE_RAINBOW) ? rlpg_pkg::MODE_OFF :
                             mode_ff + 3'd1;
               end
               rlpg_pkg::CMD_SET_MODE: begin
                  req_m    = (mval_ff >= CW'(rlpg_pkg::NUM_MODES)) ? rlpg_pkg::MODE_OFF :
                             mval_ff[rlpg_pkg::MODE_W-1:0];
                  enter_go = (req_m != mode_ff);
                  enter_m  = req_m;
               end
               rlpg_pkg::CMD_SET_COLOR: begin
                  mode_in    = rlpg_pkg::MODE_OFF;
                  led_in     = rgb_req_ff;
                  changed_in = 1'b1;
               end
               rlpg_pkg::CMD_LED_OFF: begin
                  mode_in    = rlpg_pkg::MODE_OFF;
                  led_in     = '0;
                  changed_in = 1'b1;
               end
               default: begin
                  // unused codes leave everything as it is
               end
            endcase

            if (enter_go) begin
               mode_in    = enter_m;
               changed_in = 1'b1;
               if (enter_m != rlpg_pkg::MODE_OFF) begin
                  cnt_in = period_of(enter_m, flash_period_ff, breathe_period_ff,
                                     strobe_period_ff, rainbow_period_ff);
               end
               unique case (enter_m)
                  rlpg_pkg::MODE_FLASH: begin
                     led_in = rlpg_pkg::rlpg_rgb_type'(rnd_ff[23:0]);
                  end
                  rlpg_pkg::MODE_BREATHE: begin
                     // dark start, so the color is black whatever hue is picked
                     need_mod_in = 1'b1;
                     bright_in   = '0;
                     fading_in   = 1'b0;
                     led_in      = '0;
                  end
                  rlpg_pkg::MODE_STROBE: begin
                     strobe_off_in = 1'b0;
                     led_in = rlpg_pkg::rlpg_rgb_type'(rnd_ff[23:0]);
                  end
                  rlpg_pkg::MODE_RAINBOW: begin
                     hue_in      = '0;
                     need_hsv_in = 1'b1;
                     v_in        = rainbow_bright_ff;
                  end
                  default: begin
                     led_in = '0;
                  end
               endcase
            end
         end

         rlpg_pkg::ST_MOD: begin
            rnd_in     = rnd_ff << MOD_DIGIT_W;
            rem_in     = rem_next;
            mod_cnt_in = mod_cnt_ff + MOD_CNT_W'(1);
            if (mod_last) hue_in = rem_next;
         end

         rlpg_pkg::ST_HSV_Q: begin
            mul_in = product;
         end

         rlpg_pkg::ST_HSV_T: begin
            q_in   = mul_ff[2*CW-1:CW];
            mul_in = product;
         end

         rlpg_pkg::ST_HSV_PACK: begin
            led_in = hsv_color;
         end

         rlpg_pkg::ST_FINISH: begin
            // result goes out through the response register
         end

         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // configuration writes
   // ------------------------------------------------------------------
   always_comb begin
      flash_period_in   = flash_period_ff;
      breathe_period_in = breathe_period_ff;
      strobe_period_in  = strobe_period_ff;
      rainbow_period_in = rainbow_period_ff;
      rainbow_bright_in = rainbow_bright_ff;
      if (csr_we) begin
         unique case (csr_index)
            rlpg_pkg::CSR_FLASH_PERIOD:   flash_period_in   = csr_wdata;
            rlpg_pkg::CSR_BREATHE_PERIOD: breathe_period_in = csr_wdata;
            rlpg_pkg::CSR_STROBE_PERIOD:  strobe_period_in  = csr_wdata;
            rlpg_pkg::CSR_RAINBOW_PERIOD: rainbow_period_in = csr_wdata;
            rlpg_pkg::CSR_RAINBOW_BRIGHT: rainbow_bright_in = csr_wdata;
            default: begin
               // writes past the register list are dropped
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // response register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_color_in   = rsp_color_ff;
      rsp_mode_in    = rsp_mode_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_color_in   = led_ff;
         rsp_mode_in    = mode_ff;
         rsp_changed_in = changed_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.red           = rsp_color_ff.red;
   assign rsp_bus.green         = rsp_color_ff.green;
   assign rsp_bus.blue          = rsp_color_ff.blue;
   assign rsp_bus.mode          = rsp_mode_ff;
   assign rsp_bus.color_changed = rsp_changed_ff;

   // control and pattern state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= rlpg_pkg::ST_IDLE;
         flash_period_ff   <= 8'd200;
         breathe_period_ff <= 8'd12;
         strobe_period_ff  <= 8'd50;
         rainbow_period_ff <= 8'd5;
         rainbow_bright_ff <= 8'd180;
         mode_ff           <= rlpg_pkg::MODE_OFF;
         cnt_ff            <= '0;
         hue_ff            <= '0;
         bright_ff         <= '0;
         fading_ff         <= 1'b0;
         strobe_off_ff     <= 1'b0;
         led_ff            <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         flash_period_ff   <= flash_period_in;
         breathe_period_ff <= breathe_period_in;
         strobe_period_ff  <= strobe_period_in;
         rainbow_period_ff <= rainbow_period_in;
         rainbow_bright_ff <= rainbow_bright_in;
         mode_ff           <= mode_in;
         cnt_ff            <= cnt_in;
         hue_ff            <= hue_in;
         bright_ff         <= bright_in;
         fading_ff         <= fading_in;
         strobe_off_ff     <= strobe_off_in;
         led_ff            <= led_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      mval_ff        <= mval_in;
      rgb_req_ff     <= rgb_req_in;
      rnd_ff         <= rnd_in;
      changed_ff     <= changed_in;
      need_mod_ff    <= need_mod_in;
      need_hsv_ff    <= need_hsv_in;
      v_ff           <= v_in;
      rem_ff         <= rem_in;
      mod_cnt_ff     <= mod_cnt_in;
      mul_ff         <= mul_in;
      q_ff           <= q_in;
      rsp_color_ff   <= rsp_color_in;
      rsp_mode_ff    <= rsp_mode_in;
      rsp_changed_ff <= rsp_changed_in;
   end

endmodule

FILE: hw/rtl/rlpg_checker.sv
`include "rgb_led_pattern_generator_macros.svh"

module rlpg_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [rlpg_pkg::MODE_W-1:0]       rsp_mode
);

   // no result beat straight out of reset
   `RLPG_ASSERT(a_reset_clears_rsp, reset |=> !rsp_valid)

   // a stalled result beat stays offered
   `RLPG_ASSERT_RST(a_rsp_held, rsp_valid && !rsp_ready |=> rsp_valid)

   // reported mode is always a real pattern
   `RLPG_ASSERT_RST(a_mode_range, rsp_valid |-> rsp_mode <= rlpg_pkg::MODE_RAINBOW)

   // one request at a time: busy right after a request beat
   `RLPG_ASSERT(a_busy_after_accept, !reset && req_valid && req_ready |=> !req_ready)

endmodule

bind rgb_led_pattern_generator rlpg_checker u_rlpg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_mode  (rsp_bus.mode)
);

FILE: bench/rgb_led_pattern_generator_tb.sv
module rgb_led_pattern_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rlpg_pkg::*;

   // spare command codes the block must ignore
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   localparam int unsigned NUM_REGS    = 5;
   localparam int unsigned HUE_SPAN    = 360;
   localparam int unsigned LEVEL_STEP  = 3;
   localparam int          STALL_LIMIT = 3000;   // cycles with no beat on either side
   localparam int          LONG_HOLD   = 300;    // receiver back-pressure stretch
   localparam int          SETTLE_CYCLES = 20;   // well past the slowest item
   localparam int          PHASE_ITEMS = 175;
   localparam int          NUM_PHASES  = 8;

   // one predicted result beat
   typedef struct packed {
      rlpg_rgb_type      color;
      logic [MODE_W-1:0] mode;
      logic              changed;
   } led_beat_t;

   // one row of the directed table: either a register write or a request beat
   typedef struct {
      logic                  is_csr;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      logic [CMD_W-1:0]      cmd;
      logic [CHAN_W-1:0]     mv;
      logic [CHAN_W-1:0]     r;
      logic [CHAN_W-1:0]     g;
      logic [CHAN_W-1:0]     b;
      logic [RND_W-1:0]      rnd;
      logic                  pinned;
      led_beat_t             want;
   } stim_row_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rlpg_req_if req_bus ();
   rlpg_rsp_if rsp_bus ();

   rgb_led_pattern_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // pattern predictor: own copy of the registers and the pattern state
   // ------------------------------------------------------------------
   logic [CSR_DATA_W-1:0] cfg_reg [NUM_REGS];
   logic [MODE_W-1:0]     pm_mode;
   logic [7:0]            pm_count;
   logic [HUE_W-1:0]      pm_hue;
   logic [CHAN_W-1:0]     pm_level;
   logic                  pm_falling;
   logic                  pm_dark;
   rlpg_rgb_type          pm_color;

   led_beat_t predicted_leds [$];   // results still owed by the block
   int        mismatches = 0;
   int        beats_seen = 0;

   // directed rows may pin the expected beat instead of taking the prediction
   logic      pin_on = 1'b0;
   led_beat_t pin_beat = '0;

   // receiver back-pressure request, cleared by the receiver once taken
   logic      hold_req = 1'b0;

   int        burst_left = 0;
   int        gap_len = 0;

   task automatic reset_model();
      cfg_reg[CSR_FLASH_PERIOD]   = 8'd200;
      cfg_reg[CSR_BREATHE_PERIOD] = 8'd12;
      cfg_reg[CSR_STROBE_PERIOD]  = 8'd50;
      cfg_reg[CSR_RAINBOW_PERIOD] = 8'd5;
      cfg_reg[CSR_RAINBOW_BRIGHT] = 8'd180;
      pm_mode    = MODE_OFF;
      pm_count   = '0;
      pm_hue     = '0;
      pm_level   = '0;
      pm_falling = 1'b0;
      pm_dark    = 1'b0;
      pm_color   = '0;
   endtask

   // integer hsv to rgb at full saturation; sectors past the sixth use the last one
   function automatic rlpg_rgb_type hsv_color(input logic [HUE_W-1:0] h,
                                              input logic [CHAN_W-1:0] v);
      int unsigned  sector, frac, vv, q, t;
      rlpg_rgb_type c;
      vv     = v;
      sector = h / 60;
      frac   = (h - sector * 60) * 255 / 60;
      q      = (vv * (255 - ((255 * frac) >> 8))) >> 8;
      t      = (vv * (255 - ((255 * (255 - frac)) >> 8))) >> 8;
      case (sector)
         0: c = {v, t[7:0], 8'd0};
         1: c = {q[7:0], v, 8'd0};
         2: c = {8'd0, v, t[7:0]};
         3: c = {8'd0, q[7:0], v};
         4: c = {t[7:0], 8'd0, v};
         default: c = {v, 8'd0, q[7:0]};
      endcase
      return c;
   endfunction

   function automatic logic [7:0] period_for(input logic [MODE_W-1:0] m);
      case (m)
         MODE_FLASH:   return cfg_reg[CSR_FLASH_PERIOD];
         MODE_BREATHE: return cfg_reg[CSR_BREATHE_PERIOD];
         MODE_STROBE:  return cfg_reg[CSR_STROBE_PERIOD];
         default:      return cfg_reg[CSR_RAINBOW_PERIOD];
      endcase
   endfunction

   // entry into a mode starts its pattern on the same beat
   task automatic start_pattern(input logic [MODE_W-1:0] m, input logic [RND_W-1:0] rnd);
      pm_mode = m;
      case (m)
         MODE_FLASH: pm_color = rnd[23:0];
         MODE_BREATHE: begin
            pm_hue     = rnd % HUE_SPAN;
            pm_level   = '0;
            pm_falling = 1'b0;
            pm_color   = hsv_color(pm_hue, pm_level);
         end
         MODE_STROBE: begin
            pm_dark  = 1'b0;
            pm_color = rnd[23:0];
         end
         MODE_RAINBOW: begin
            pm_hue   = '0;
            pm_color = hsv_color(pm_hue, cfg_reg[CSR_RAINBOW_BRIGHT]);
         end
         default: pm_color = '0;
      endcase
      if (m != MODE_OFF) pm_count = period_for(m);
   endtask

   // one pattern step when the countdown runs out
   task automatic advance_pattern(input logic [RND_W-1:0] rnd);
      case (pm_mode)
         MODE_FLASH: pm_color = rnd[23:0];
         MODE_BREATHE: begin
            if (!pm_falling) begin
               // top is shown once more as the fade starts
               if (pm_level == 8'hFF) pm_falling = 1'b1;
               else if (pm_level > 8'hFF - LEVEL_STEP) pm_level = 8'hFF;
               else pm_level = pm_level + LEVEL_STEP;
            end else if (pm_level == 0) begin
               // bottom reached: fresh hue, rise again
               pm_falling = 1'b0;
               pm_hue     = rnd % HUE_SPAN;
            end else if (pm_level < LEVEL_STEP) begin
               pm_level = '0;
            end else begin
               pm_level = pm_level - LEVEL_STEP;
            end
            pm_color = hsv_color(pm_hue, pm_level);
         end
         MODE_STROBE: begin
            if (pm_dark) begin
               pm_dark  = 1'b0;
               pm_color = rnd[23:0];
            end else begin
               pm_dark  = 1'b1;
               pm_color = '0;
            end
         end
         default: begin
            pm_hue   = (pm_hue >= HUE_SPAN - 1) ? '0 : pm_hue + 1'b1;
            pm_color = hsv_color(pm_hue, cfg_reg[CSR_RAINBOW_BRIGHT]);
         end
      endcase
      pm_count = period_for(pm_mode);
   endtask

   task automatic predict_led(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] mv,
                              input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b, input logic [RND_W-1:0] rnd,
                              output led_beat_t beat);
      logic              chg;
      logic [MODE_W-1:0] m;
      chg = 1'b0;
      case (cmd)
         CMD_TICK: begin
            // a zero countdown counts as expired, so a zero period acts as one
            if (pm_mode != MODE_OFF) begin
               if (pm_count <= 1) begin
                  advance_pattern(rnd);
                  chg = 1'b1;
               end else begin
                  pm_count = pm_count - 1'b1;
               end
            end
         end
         CMD_BUTTON: begin
            m = (pm_mode == MODE_RAINBOW) ? MODE_OFF : pm_mode + 1'b1;
            start_pattern(m, rnd);
            chg = 1'b1;
         end
         CMD_SET_MODE: begin
            // out-of-range requests fall back to off; same mode is a no-op
            m = (mv >= NUM_MODES) ? MODE_OFF : mv[MODE_W-1:0];
            if (m != pm_mode) begin
               start_pattern(m, rnd);
               chg = 1'b1;
            end
         end
         CMD_SET_COLOR: begin
            pm_mode  = MODE_OFF;
            pm_color = {r, g, b};
            chg      = 1'b1;
         end
         CMD_LED_OFF: begin
            pm_mode  = MODE_OFF;
            pm_color = '0;
            chg      = 1'b1;
         end
         default: ;   // spare codes leave everything as it is
      endcase
      beat.color   = pm_color;
      beat.mode    = pm_mode;
      beat.changed = chg;
   endtask

   task automatic report_mismatch(input string msg);
      $display("[%0t] beat %0d: %s", $realtime, beats_seen, msg);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // monitor: everything sampled at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      led_beat_t want;
      if (reset) begin
         reset_model();
      end else begin
         if (csr_we && csr_index < NUM_REGS) cfg_reg[csr_index] = csr_wdata;
         if (req_bus.valid && req_bus.ready) begin
            predict_led(req_bus.command, req_bus.mode_value, req_bus.red_in,
                        req_bus.green_in, req_bus.blue_in, req_bus.random_word, want);
            if (pin_on) want = pin_beat;
            predicted_leds.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_leds.size() == 0) begin
               report_mismatch("result beat with nothing pending");
            end else begin
               want = predicted_leds.pop_front();
               if (rsp_bus.red !== want.color.red)
                  report_mismatch($sformatf("red %0h, want %0h", rsp_bus.red, want.color.red));
               if (rsp_bus.green !== want.color.green)
                  report_mismatch($sformatf("green %0h, want %0h",
                                            rsp_bus.green, want.color.green));
               if (rsp_bus.blue !== want.color.blue)
                  report_mismatch($sformatf("blue %0h, want %0h",
                                            rsp_bus.blue, want.color.blue));
               if (rsp_bus.mode !== want.mode)
                  report_mismatch($sformatf("mode %0d, want %0d", rsp_bus.mode, want.mode));
               if (rsp_bus.color_changed !== want.changed)
                  report_mismatch($sformatf("color_changed %0b, want %0b",
                                            rsp_bus.color_changed, want.changed));
            end
            beats_seen++;
         end
      end
   end

   // watchdog: too long with no beat on either channel ends the run
   always @(posedge clock) begin : watchdog
      int idle_cycles;
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[%0t] no beat for %0d cycles", $realtime, STALL_LIMIT);
         $display("rgb_led_pattern_generator_tb: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // receiver: ready changes at the falling edge, in segments of mixed style
   // ------------------------------------------------------------------
   initial begin : receiver
      int style;
      int seg;
      rsp_bus.ready = 1'b0;
      forever begin
         if (hold_req) begin
            // long hold-off so the block fills up and stalls its input
            hold_req      = 1'b0;
            rsp_bus.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         style = $urandom_range(0, 3);
         seg   = $urandom_range(1, 40);
         repeat (seg) begin
            case (style)
               0:       rsp_bus.ready = 1'b1;
               1:       rsp_bus.ready = $urandom_range(0, 1);
               2:       rsp_bus.ready = ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready = ($urandom_range(0, 7) != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------

   // offer one beat from a falling edge, return at the falling edge after it is taken;
   // bursts of back-to-back beats alternate with random gaps
   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] mv,
                            input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b, input logic [RND_W-1:0] rnd,
                            input logic pinned, input led_beat_t pexp);
      req_bus.valid       = 1'b1;
      req_bus.command     = cmd;
      req_bus.mode_value  = mv;
      req_bus.red_in      = r;
      req_bus.green_in    = g;
      req_bus.blue_in     = b;
      req_bus.random_word = rnd;
      pin_on              = pinned;
      pin_beat            = pexp;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap_len > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap_len) @(negedge clock);
         end
      end
   endtask

   // beat with random payload around a chosen command and mode value
   task automatic send_rand(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] mv);
      send_beat(cmd, mv, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom, 1'b0, '0);
   endtask

   // stop offering, let every owed result arrive and the block go idle
   task automatic settle();
      req_bus.valid = 1'b0;
      while (predicted_leds.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   stim_row_t directed_rows [$];

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      stim_row_t row;
      row         = '{default: '0};
      row.is_csr  = 1'b1;
      row.reg_idx = idx;
      row.reg_val = val;
      directed_rows.push_back(row);
   endtask

   // request row checked against the predictor
   task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] mv,
                           input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                           input logic [CHAN_W-1:0] b, input logic [RND_W-1:0] rnd);
      stim_row_t row;
      row     = '{default: '0};
      row.cmd = cmd;
      row.mv  = mv;
      row.r   = r;
      row.g   = g;
      row.b   = b;
      row.rnd = rnd;
      directed_rows.push_back(row);
   endtask

   // request row with its result written out by hand
   task automatic add_pinned(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] mv,
                             input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b, input logic [RND_W-1:0] rnd,
                             input rlpg_rgb_type color, input logic [MODE_W-1:0] mode,
                             input logic chg);
      add_item(cmd, mv, r, g, b, rnd);
      directed_rows[$].pinned       = 1'b1;
      directed_rows[$].want.color   = color;
      directed_rows[$].want.mode    = mode;
      directed_rows[$].want.changed = chg;
   endtask

   // random phase: mostly a mode entry followed by a run of ticks, plus noise
   task automatic run_phase(input int phase);
      int                    sent;
      int                    pick;
      int                    run_len;
      int unsigned           idx;
      logic [CSR_DATA_W-1:0] val;
      settle();
      for (idx = 0; idx < NUM_REGS; idx++) begin
         case (phase)
            0:       val = (idx == CSR_RAINBOW_BRIGHT) ? 8'd0 : 8'd1;
            1:       val = 8'hFF;
            2:       val = (idx == CSR_RAINBOW_BRIGHT) ? $urandom_range(0, 255) : 8'd0;
            default: begin
               if (idx == CSR_RAINBOW_BRIGHT || $urandom_range(0, 3) == 0)
                  val = $urandom_range(0, 255);
               else
                  val = $urandom_range(0, 6);
            end
         endcase
         write_reg(idx, val);
      end
      if (phase == 3) hold_req = 1'b1;
      sent = 0;
      // fast periods: walk a full breathe cycle, or the whole hue circle with its wrap
      if (phase == 0 || phase == 2) begin
         send_rand(CMD_SET_MODE, (phase == 0) ? 8'(MODE_BREATHE) : 8'(MODE_RAINBOW));
         run_len = (phase == 0) ? $urandom_range(180, 260) : $urandom_range(365, 380);
         repeat (run_len) send_rand(CMD_TICK, $urandom_range(0, 255));
         sent = run_len + 1;
      end
      while (sent < PHASE_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            if ($urandom_range(0, 1))
               send_rand(CMD_BUTTON, $urandom_range(0, 255));
            else if ($urandom_range(0, 3) == 0)
               send_rand(CMD_SET_MODE, $urandom_range(0, 255));
            else
               send_rand(CMD_SET_MODE, $urandom_range(MODE_OFF, MODE_RAINBOW));
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(1, 40);
            repeat (run_len) send_rand(CMD_TICK, $urandom_range(0, 255));
            sent += run_len + 1;
         end else if (pick < 70) begin
            send_rand(CMD_SET_COLOR, $urandom_range(0, 255));
            sent++;
         end else if (pick < 78) begin
            send_rand(CMD_LED_OFF, $urandom_range(0, 255));
            sent++;
         end else if (pick < 85) begin
            // ignored by the block, not counted
            send_rand($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI), $urandom_range(0, 255));
         end else begin
            send_rand($urandom_range(0, 7), $urandom_range(0, 255));
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin : main_seq
      stim_row_t row;
      int        phase;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.command     = CMD_TICK;
      req_bus.mode_value  = '0;
      req_bus.red_in      = '0;
      req_bus.green_in    = '0;
      req_bus.blue_in     = '0;
      req_bus.random_word = '0;

      // directed table at reset register values
      add_pinned(CMD_TICK,      8'd0,   8'h00, 8'h00, 8'h00, 32'h0,
                 24'h000000, MODE_OFF, 1'b0);            // tick while off after reset
      add_pinned(CMD_SPARE_HI,  8'd0,   8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF,
                 24'h000000, MODE_OFF, 1'b0);            // spare code ignored
      add_pinned(CMD_SET_COLOR, 8'd0,   8'hFF, 8'h00, 8'h80, 32'h0,
                 24'hFF0080, MODE_OFF, 1'b1);
      add_pinned(CMD_SET_MODE,  8'd0,   8'h00, 8'h00, 8'h00, 32'h0,
                 24'hFF0080, MODE_OFF, 1'b0);            // same mode: color held
      add_pinned(CMD_LED_OFF,   8'd0,   8'hFF, 8'hFF, 8'hFF, 32'h0,
                 24'h000000, MODE_OFF, 1'b1);
      add_pinned(CMD_SET_COLOR, 8'd0,   8'hFF, 8'hFF, 8'hFF, 32'h0,
                 24'hFFFFFF, MODE_OFF, 1'b1);
      add_pinned(CMD_SET_MODE,  8'hFF,  8'h00, 8'h00, 8'h00, 32'h0,
                 24'hFFFFFF, MODE_OFF, 1'b0);            // out of range means off
      add_pinned(CMD_BUTTON,    8'd0,   8'h00, 8'h00, 8'h00, 32'hAB123456,
                 24'h123456, MODE_FLASH, 1'b1);          // top byte of the word unused
      add_pinned(CMD_TICK,      8'd0,   8'h00, 8'h00, 8'h00, 32'h0,
                 24'h123456, MODE_FLASH, 1'b0);          // countdown only
      add_pinned(CMD_SET_MODE,  8'd1,   8'h00, 8'h00, 8'h00, 32'h0,
                 24'h123456, MODE_FLASH, 1'b0);
      add_pinned(CMD_SET_MODE,  8'd3,   8'h00, 8'h00, 8'h00, 32'hFFFFFFFF,
                 24'hFFFFFF, MODE_STROBE, 1'b1);
      add_pinned(CMD_SET_MODE,  8'd2,   8'h00, 8'h00, 8'h00, 32'hFFFFFFFF,
                 24'h000000, MODE_BREATHE, 1'b1);        // breathe starts dark
      add_pinned(CMD_SET_MODE,  8'd4,   8'h00, 8'h00, 8'h00, 32'h0,
                 24'hB40000, MODE_RAINBOW, 1'b1);        // hue 0 at brightness 180
      add_pinned(CMD_BUTTON,    8'd0,   8'h00, 8'h00, 8'h00, 32'h0,
                 24'h000000, MODE_OFF, 1'b1);            // button wraps to off
      add_pinned(CMD_SET_MODE,  8'd5,   8'h00, 8'h00, 8'h00, 32'h0,
                 24'h000000, MODE_OFF, 1'b0);
      // zero period, hue in the last sector
      add_csr(CSR_BREATHE_PERIOD, 8'd0);
      add_item(CMD_SET_MODE, 8'd2, 8'h00, 8'h00, 8'h00, 32'd359);
      add_item(CMD_TICK,     8'd0, 8'h00, 8'h00, 8'h00, 32'h0);
      add_item(CMD_TICK,     8'd0, 8'h00, 8'h00, 8'h00, 32'h0);
      add_csr(CSR_RAINBOW_PERIOD, 8'd1);
      add_csr(CSR_RAINBOW_BRIGHT, 8'hFF);
      add_pinned(CMD_SET_MODE, 8'd4, 8'h00, 8'h00, 8'h00, 32'h0,
                 24'hFF0000, MODE_RAINBOW, 1'b1);
      add_item(CMD_TICK,     8'd0, 8'h00, 8'h00, 8'h00, 32'h0);
      add_csr(CSR_STROBE_PERIOD, 8'd1);
      add_pinned(CMD_SET_MODE, 8'd3, 8'h00, 8'h00, 8'h00, 32'h00C0FFEE,
                 24'hC0FFEE, MODE_STROBE, 1'b1);
      add_pinned(CMD_TICK,     8'd0, 8'h00, 8'h00, 8'h00, 32'h0,
                 24'h000000, MODE_STROBE, 1'b1);         // on phase goes dark
      add_pinned(CMD_TICK,     8'd0, 8'h00, 8'h00, 8'h00, 32'h00000001,
                 24'h000001, MODE_STROBE, 1'b1);         // dark phase takes a new color
      add_csr(CSR_FLASH_PERIOD, 8'hFF);
      add_pinned(CMD_SET_MODE, 8'd1, 8'h00, 8'h00, 8'h00, 32'h0,
                 24'h000000, MODE_FLASH, 1'b1);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < directed_rows.size(); i++) begin
         row = directed_rows[i];
         if (row.is_csr) begin
            settle();
            write_reg(row.reg_idx, row.reg_val);
         end else begin
            send_beat(row.cmd, row.mv, row.r, row.g, row.b, row.rnd, row.pinned, row.want);
         end
      end

      for (phase = 0; phase < NUM_PHASES; phase++) run_phase(phase);

      settle();
      if (mismatches == 0)
         $display("rgb_led_pattern_generator_tb: clean");
      else
         $display("rgb_led_pattern_generator_tb: errors");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/rlpg_pkg.sv
hw/rtl/rlpg_req_if.sv
hw/rtl/rlpg_rsp_if.sv
hw/rtl/rgb_led_pattern_generator.sv
hw/rtl/rlpg_checker.sv
bench/rgb_led_pattern_generator_tb.sv
